// ===== sv/scst_pkg.sv =====
// Shared types and codes for the sorted colour stop table.
// Depends on nothing; every other file of the block imports it.
package scst_pkg;

   // Fixed-point format of the levels: one is 1 << FRACTION_BITS in a 16-bit field.
   localparam int FRACTION_BITS = 15;

   typedef logic [2:0]  cmd_type;
   typedef logic [1:0]  status_type;
   typedef logic [15:0] level_type;

   localparam cmd_type CMD_ADD    = 3'd0;
   localparam cmd_type CMD_SET    = 3'd1;
   localparam cmd_type CMD_REMOVE = 3'd2;
   localparam cmd_type CMD_READ   = 3'd3;
   localparam cmd_type CMD_FILTER = 3'd4;
   localparam cmd_type CMD_CLEAR  = 3'd5;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_BAD_INDEX = 2'd2;

   // One table entry: four unsigned levels and two opaque tags.
   typedef struct packed {
      level_type name;
      level_type color;
      level_type shade;
      level_type opacity;
      level_type mid;
      level_type ramp;
   } stop_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       fwd_start;
      logic       fwd_run;
      logic       fwd_commit;
      logic       ins_start;
      logic       ins_run;
      logic       ins_zero;
      logic       rd_start;
      logic       clear;
      logic       emit;
      status_type status;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    idx_bad;
      logic    fwd_done;
      logic    dropped;
      logic    placed;
      logic    bottom;
      logic    rsp_free;
   } sts_type;

endpackage

// ===== sv/scst_if.sv =====
// Valid/ready channel interfaces for the command and response items.
// Depends on scst_pkg for the field types.
interface scst_req_if import scst_pkg::*; ();
   logic              valid;
   logic              ready;
   cmd_type           cmd;
   logic signed [16:0] ramp_in;
   logic signed [16:0] mid_in;
   logic signed [16:0] opacity_in;
   logic signed [16:0] shade_in;
   logic [15:0]       color_id;
   logic [15:0]       name_id;
   logic [7:0]        index_in;

   modport source (output valid, cmd, ramp_in, mid_in, opacity_in, shade_in, color_id,
                   name_id, index_in, input ready);
   modport sink (input valid, cmd, ramp_in, mid_in, opacity_in, shade_in, color_id,
                 name_id, index_in, output ready);
endinterface

interface scst_rsp_if import scst_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   logic [4:0] stop_count;
   logic [7:0] slot_index;
   level_type  ramp_out;
   level_type  mid_out;
   level_type  opacity_out;
   level_type  shade_out;
   level_type  color_out;
   level_type  name_out;

   modport source (output valid, status, stop_count, slot_index, ramp_out, mid_out,
                   opacity_out, shade_out, color_out, name_out, input ready);
   modport sink (input valid, status, stop_count, slot_index, ramp_out, mid_out,
                 opacity_out, shade_out, color_out, name_out, output ready);
endinterface

// ===== sv/scst_datapath.sv =====
// Datapath of the stop table: entry memory, scan pointers, item and response registers.
// Depends on scst_pkg; driven by scst_controller through ctl_type and sts_type.
module scst_datapath import scst_pkg::*; #(
   parameter int MAX_STOPS     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   output sts_type            sts,
   input  cmd_type            req_cmd,
   input  logic signed [16:0] req_ramp_in,
   input  logic signed [16:0] req_mid_in,
   input  logic signed [16:0] req_opacity_in,
   input  logic signed [16:0] req_shade_in,
   input  logic [15:0]        req_color_id,
   input  logic [15:0]        req_name_id,
   input  logic [7:0]         req_index_in,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output status_type         rsp_status,
   output logic [4:0]         rsp_count,
   output logic [7:0]         rsp_slot,
   output stop_type           rsp_stop
);

   localparam int IDX_W = $clog2(MAX_STOPS);
   localparam int CNT_W = $clog2(MAX_STOPS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STOPS);
   localparam logic [31:0] ONE_Q = 32'(1) << FRACTION_BITS;

   function automatic level_type clamp_unit(input logic signed [16:0] x);
      level_type res;
      res = x[15:0];
      if (x[16]) begin
         res = '0;
      end else if (32'(x[15:0]) > ONE_Q) begin
         res = ONE_Q[15:0];
      end
      return res;
   endfunction

   stop_type table_mem [MAX_STOPS];
   stop_type rd_data_ff;

   cmd_type            cmd_ff;
   logic signed [16:0] raw_ff;
   stop_type           new_ff;
   logic [7:0]         idx_ff;

   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] rd_tag_ff, rd_tag_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] slot_ff, slot_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             dropped_ff, dropped_in;
   logic             one_seen_ff, one_seen_in;
   logic             placed_ff, placed_in;
   logic             bottom_ff, bottom_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [4:0]       rsp_count_ff;
   logic [7:0]       rsp_slot_ff;
   stop_type         rsp_stop_ff;

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   stop_type         wr_data;

   logic             entry_zero, entry_one, entry_match, entry_above;
   logic [CNT_W-1:0] tag_next, rd_ptr_dec;
   logic             show_slot, show_read;

   assign entry_zero  = rd_data_ff.ramp == 16'd0;
   assign entry_one   = 32'(rd_data_ff.ramp) == ONE_Q;
   assign entry_match = !raw_ff[16] && (rd_data_ff.ramp == raw_ff[15:0]);
   assign entry_above = rd_data_ff.ramp > new_ff.ramp;
   assign tag_next    = rd_tag_ff + CNT_W'(1);
   assign rd_ptr_dec  = rd_ptr_ff - CNT_W'(1);

   always_comb begin
      held_in     = held_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_tag_in   = rd_tag_ff;
      wr_ptr_in   = wr_ptr_ff;
      slot_in     = slot_ff;
      rd_vld_in   = 1'b0;
      dropped_in  = dropped_ff;
      one_seen_in = one_seen_ff;
      placed_in   = placed_ff;
      bottom_in   = bottom_ff;
      rd_en       = 1'b0;
      rd_addr     = rd_ptr_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = wr_ptr_ff[IDX_W-1:0];
      wr_data     = rd_data_ff;

      if (ctl.fwd_start) begin
         rd_ptr_in   = '0;
         wr_ptr_in   = '0;
         dropped_in  = 1'b0;
         one_seen_in = 1'b0;
      end

      // Forward pass: read every entry in turn and write back the kept ones
      // compacted towards the front.
      if (ctl.fwd_run) begin
         if (rd_ptr_ff < held_ff) begin
            rd_en     = 1'b1;
            rd_addr   = rd_ptr_ff[IDX_W-1:0];
            rd_tag_in = rd_ptr_ff;
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            rd_vld_in = 1'b1;
         end
         if (rd_vld_ff) begin
            case (cmd_ff)
               CMD_FILTER: begin
                  // Stops at zero lead the sorted table, so each one simply
                  // overwrites slot 0 and the last of them remains.
                  if (entry_zero) begin
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_ptr_in = CNT_W'(1);
                  end else if (!(entry_one && one_seen_ff)) begin
                     wr_en     = 1'b1;
                     wr_ptr_in = wr_ptr_ff + CNT_W'(1);
                     if (entry_one) begin
                        one_seen_in = 1'b1;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (9'(rd_tag_ff) != 9'(idx_ff)) begin
                     wr_en     = 1'b1;
                     wr_ptr_in = wr_ptr_ff + CNT_W'(1);
                  end
               end
               default: begin
                  if (!dropped_ff && entry_match) begin
                     dropped_in = 1'b1;
                  end else begin
                     wr_en     = 1'b1;
                     wr_ptr_in = wr_ptr_ff + CNT_W'(1);
                  end
               end
            endcase
         end
      end

      if (ctl.fwd_commit) begin
         held_in = wr_ptr_ff;
      end

      if (ctl.ins_start) begin
         rd_ptr_in = held_ff;
         placed_in = 1'b0;
         bottom_in = 1'b0;
      end

      // Backward pass: move entries above the new position up by one until
      // the first entry at or below it, then place the new stop behind it.
      if (ctl.ins_run) begin
         if (rd_vld_ff && !placed_ff) begin
            wr_en   = 1'b1;
            wr_addr = tag_next[IDX_W-1:0];
            if (entry_above) begin
               wr_data = rd_data_ff;
               if (rd_tag_ff == '0) begin
                  bottom_in = 1'b1;
               end
            end else begin
               wr_data   = new_ff;
               slot_in   = tag_next;
               placed_in = 1'b1;
               held_in   = held_ff + CNT_W'(1);
            end
         end
         if ((rd_ptr_ff != '0) && !placed_ff && !(rd_vld_ff && !entry_above)) begin
            rd_en     = 1'b1;
            rd_addr   = rd_ptr_dec[IDX_W-1:0];
            rd_tag_in = rd_ptr_dec;
            rd_ptr_in = rd_ptr_dec;
            rd_vld_in = 1'b1;
         end
      end

      if (ctl.ins_zero) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = new_ff;
         slot_in = '0;
         held_in = held_ff + CNT_W'(1);
      end

      if (ctl.rd_start) begin
         rd_en   = 1'b1;
         rd_addr = idx_ff[IDX_W-1:0];
      end

      if (ctl.clear) begin
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff         <= req_cmd;
         raw_ff         <= req_ramp_in;
         idx_ff         <= req_index_in;
         new_ff.ramp    <= clamp_unit(req_ramp_in);
         new_ff.mid     <= clamp_unit(req_mid_in);
         new_ff.opacity <= clamp_unit(req_opacity_in);
         new_ff.shade   <= clamp_unit(req_shade_in);
         new_ff.color   <= req_color_id;
         new_ff.name    <= req_name_id;
      end
      rd_ptr_ff <= rd_ptr_in;
      rd_tag_ff <= rd_tag_in;
      wr_ptr_ff <= wr_ptr_in;
      slot_ff   <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         dropped_ff   <= 1'b0;
         one_seen_ff  <= 1'b0;
         placed_ff    <= 1'b0;
         bottom_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rd_vld_ff    <= rd_vld_in;
         dropped_ff   <= dropped_in;
         one_seen_ff  <= one_seen_in;
         placed_ff    <= placed_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = ctl.emit | (rsp_valid_ff & ~rsp_ready);
   assign show_slot = (ctl.status == ST_OK) && ((cmd_ff == CMD_ADD) || (cmd_ff == CMD_SET));
   assign show_read = (ctl.status == ST_OK) && (cmd_ff == CMD_READ);

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_status_ff <= ctl.status;
         rsp_count_ff  <= 5'(held_ff);
         rsp_stop_ff   <= show_read ? rd_data_ff : '0;
         if (show_read) begin
            rsp_slot_ff <= idx_ff;
         end else if (show_slot) begin
            rsp_slot_ff <= 8'(slot_ff);
         end else begin
            rsp_slot_ff <= '0;
         end
      end
   end

   assign sts.cmd      = cmd_ff;
   assign sts.full     = held_ff == MAX_CNT;
   assign sts.empty    = held_ff == '0;
   assign sts.idx_bad  = 9'(idx_ff) >= 9'(held_ff);
   assign sts.fwd_done = !rd_vld_ff && (rd_ptr_ff == held_ff);
   assign sts.dropped  = dropped_ff;
   assign sts.placed   = placed_ff;
   assign sts.bottom   = bottom_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_stop   = rsp_stop_ff;

endmodule

// ===== sv/scst_controller.sv =====
// Controller of the stop table: sequences the scan passes for each command.
// Depends on scst_pkg; drives scst_datapath through ctl_type and reads sts_type.
module scst_controller import scst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_FWD       = 4'd2;
   localparam logic [3:0] S_COMMIT    = 4'd3;
   localparam logic [3:0] S_INS_PREP  = 4'd4;
   localparam logic [3:0] S_INS       = 4'd5;
   localparam logic [3:0] S_ZERO      = 4'd6;
   localparam logic [3:0] S_EMIT_OK   = 4'd7;
   localparam logic [3:0] S_EMIT_FULL = 4'd8;
   localparam logic [3:0] S_EMIT_BAD  = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff) inside
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.cmd) inside
               CMD_ADD: begin
                  if (sts.full) begin
                     state_in = S_EMIT_FULL;
                  end else if (sts.empty) begin
                     state_in = S_ZERO;
                  end else begin
                     ctl.ins_start = 1'b1;
                     state_in      = S_INS;
                  end
               end
               CMD_SET, CMD_FILTER: begin
                  ctl.fwd_start = 1'b1;
                  state_in      = S_FWD;
               end
               CMD_REMOVE: begin
                  if (sts.idx_bad) begin
                     state_in = S_EMIT_BAD;
                  end else begin
                     ctl.fwd_start = 1'b1;
                     state_in      = S_FWD;
                  end
               end
               CMD_READ: begin
                  if (sts.idx_bad) begin
                     state_in = S_EMIT_BAD;
                  end else begin
                     ctl.rd_start = 1'b1;
                     state_in     = S_EMIT_OK;
                  end
               end
               CMD_CLEAR: begin
                  ctl.clear = 1'b1;
                  state_in  = S_EMIT_OK;
               end
               default: begin
                  state_in = S_EMIT_OK;
               end
            endcase
         end
         S_FWD: begin
            ctl.fwd_run = 1'b1;
            if (sts.fwd_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            ctl.fwd_commit = 1'b1;
            if (sts.cmd == CMD_SET) begin
               // A set without a matching stop needs a free slot of its own.
               state_in = (!sts.dropped && sts.full) ? S_EMIT_FULL : S_INS_PREP;
            end else begin
               state_in = S_EMIT_OK;
            end
         end
         S_INS_PREP: begin
            if (sts.empty) begin
               state_in = S_ZERO;
            end else begin
               ctl.ins_start = 1'b1;
               state_in      = S_INS;
            end
         end
         S_INS: begin
            ctl.ins_run = 1'b1;
            if (sts.placed) begin
               state_in = S_EMIT_OK;
            end else if (sts.bottom) begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            ctl.ins_zero = 1'b1;
            state_in     = S_EMIT_OK;
         end
         S_EMIT_OK, S_EMIT_FULL, S_EMIT_BAD: begin
            if (state_ff == S_EMIT_FULL) begin
               ctl.status = ST_FULL;
            end else if (state_ff == S_EMIT_BAD) begin
               ctl.status = ST_BAD_INDEX;
            end else begin
               ctl.status = ST_OK;
            end
            if (sts.rsp_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/sorted_color_stop_table.sv =====
// Sorted colour stop table top: one item in flight, one response item per command item.
// The scans move one table entry per cycle.
// Synchronous reset empties the table (count to zero); entry contents are not cleared.
// Depends on scst_pkg, scst_if, scst_controller and scst_datapath.
module sorted_color_stop_table import scst_pkg::*; #(
   parameter int MAX_STOPS     = 16
) (
   input logic               clock,
   input logic               reset,
   scst_req_if.sink          req_if,
   scst_rsp_if.source        rsp_if
);

   ctl_type  ctl;
   sts_type  sts;
   stop_type rsp_stop;

   scst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   scst_datapath #(
      .MAX_STOPS     (MAX_STOPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_cmd        (req_if.cmd),
      .req_ramp_in    (req_if.ramp_in),
      .req_mid_in     (req_if.mid_in),
      .req_opacity_in (req_if.opacity_in),
      .req_shade_in   (req_if.shade_in),
      .req_color_id   (req_if.color_id),
      .req_name_id    (req_if.name_id),
      .req_index_in   (req_if.index_in),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_status     (rsp_if.status),
      .rsp_count      (rsp_if.stop_count),
      .rsp_slot       (rsp_if.slot_index),
      .rsp_stop       (rsp_stop)
   );

   assign rsp_if.ramp_out    = rsp_stop.ramp;
   assign rsp_if.mid_out     = rsp_stop.mid;
   assign rsp_if.opacity_out = rsp_stop.opacity;
   assign rsp_if.shade_out   = rsp_stop.shade;
   assign rsp_if.color_out   = rsp_stop.color;
   assign rsp_if.name_out    = rsp_stop.name;

endmodule

// ===== verif/sorted_color_stop_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted colour stop table: directed and random commands.
// Depends on scst_pkg, the channel interfaces in scst_if and the sorted_color_stop_table top.
module sorted_color_stop_table_tb import scst_pkg::*; ();

   localparam int MAX_STOPS    = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 64;
   localparam level_type UNIT_LEVEL = 16'd32768;
   localparam cmd_type CMD_SPARE_A = 3'd6;
   localparam cmd_type CMD_SPARE_B = 3'd7;

   typedef struct {
      cmd_type            cmd;
      logic signed [16:0] ramp;
      logic signed [16:0] mid;
      logic signed [16:0] opacity;
      logic signed [16:0] shade;
      logic [15:0]        color;
      logic [15:0]        name;
      logic [7:0]         idx;
   } stop_cmd_type;

   typedef struct {
      status_type  status;
      logic [4:0]  count;
      logic [7:0]  slot;
      stop_type    stop;
   } stop_rsp_type;

   logic clock;
   logic reset;
   scst_req_if req_ch ();
   scst_rsp_if rsp_ch ();

   sorted_color_stop_table #(.MAX_STOPS(MAX_STOPS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow copy of the table, updated as each item is accepted.
   stop_type     shadow_stops [MAX_STOPS];
   int           shadow_held;
   stop_rsp_type pending_rsp [$];

   bit idle_on;
   int error_count = 0;
   int cycle_count = 0;
   int checked_count = 0;
   int full_count = 0;
   int bad_index_count = 0;
   int cmd_tally [8];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic level_type clamp_level(logic signed [16:0] x);
      if (x < 0) return '0;
      if (x > $signed({1'b0, UNIT_LEVEL})) return UNIT_LEVEL;
      return x[15:0];
   endfunction

   function automatic void drop_stop(int at);
      int k;
      for (k = at; k + 1 < shadow_held; k++) shadow_stops[k] = shadow_stops[k + 1];
      shadow_held--;
   endfunction

   // Applies one command to the shadow table and returns the response it should give.
   function automatic stop_rsp_type apply_stop_cmd(stop_cmd_type c);
      stop_rsp_type e;
      stop_type     s;
      int           raw;
      int           hit;
      int           pos;
      int           k;
      bit           seen;
      e.status = ST_OK;
      e.slot   = '0;
      e.stop   = '0;
      case (c.cmd) inside
         CMD_ADD, CMD_SET: begin
            raw = c.ramp;
            hit = -1;
            if (c.cmd == CMD_SET) begin
               for (k = 0; k < shadow_held; k++) begin
                  if (hit < 0 && int'(shadow_stops[k].ramp) == raw) hit = k;
               end
            end
            if (hit < 0 && shadow_held == MAX_STOPS) begin
               e.status = ST_FULL;
            end else begin
               s.ramp    = clamp_level(c.ramp);
               s.mid     = clamp_level(c.mid);
               s.opacity = clamp_level(c.opacity);
               s.shade   = clamp_level(c.shade);
               s.color   = c.color;
               s.name    = c.name;
               if (hit >= 0) drop_stop(hit);
               pos = 0;
               while (pos < shadow_held && shadow_stops[pos].ramp <= s.ramp) pos++;
               for (k = shadow_held; k > pos; k--) shadow_stops[k] = shadow_stops[k - 1];
               shadow_stops[pos] = s;
               shadow_held++;
               e.slot = 8'(pos);
            end
         end
         CMD_REMOVE: begin
            if (c.idx >= shadow_held) e.status = ST_BAD_INDEX;
            else drop_stop(c.idx);
         end
         CMD_READ: begin
            if (c.idx >= shadow_held) begin
               e.status = ST_BAD_INDEX;
            end else begin
               e.slot = c.idx;
               e.stop = shadow_stops[c.idx];
            end
         end
         CMD_FILTER: begin
            // Keep the last stop at zero, scanning from the back.
            seen = 1'b0;
            k = shadow_held;
            while (k > 0) begin
               k--;
               if (shadow_stops[k].ramp == '0) begin
                  if (seen) drop_stop(k);
                  else seen = 1'b1;
               end
            end
            // Keep the first stop at one, scanning from the front.
            seen = 1'b0;
            k = 0;
            while (k < shadow_held) begin
               if (shadow_stops[k].ramp == UNIT_LEVEL && seen) begin
                  drop_stop(k);
               end else begin
                  if (shadow_stops[k].ramp == UNIT_LEVEL) seen = 1'b1;
                  k++;
               end
            end
         end
         CMD_CLEAR: shadow_held = 0;
         default: ;
      endcase
      e.count = 5'(shadow_held);
      return e;
   endfunction

   function automatic stop_cmd_type stop_cmd(cmd_type cmd, int ramp, int mid, int opacity,
                                             int shade, int color, int name, int idx);
      stop_cmd_type c;
      c.cmd     = cmd;
      c.ramp    = 17'(ramp);
      c.mid     = 17'(mid);
      c.opacity = 17'(opacity);
      c.shade   = 17'(shade);
      c.color   = 16'(color);
      c.name    = 16'(name);
      c.idx     = 8'(idx);
      return c;
   endfunction

   // Levels biased towards the clamp edges, with the whole signed range reachable.
   function automatic logic signed [16:0] random_level();
      int v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = UNIT_LEVEL;
         2: v = -int'($urandom_range(1, 65536));
         3: v = $urandom_range(32769, 65535);
         default: v = $urandom_range(0, 32768);
      endcase
      return v[16:0];
   endfunction

   function automatic stop_cmd_type random_stop_cmd();
      stop_cmd_type c;
      int           r;
      c.ramp    = random_level();
      c.mid     = random_level();
      c.opacity = random_level();
      c.shade   = random_level();
      c.color   = 16'($urandom_range(0, 65535));
      c.name    = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 4) == 0) c.idx = 8'($urandom_range(0, 255));
      else c.idx = 8'($urandom_range(0, shadow_held + 1));
      r = $urandom_range(0, 99);
      if (r < 36) begin
         c.cmd = CMD_ADD;
      end else if (r < 52) begin
         c.cmd = CMD_SET;
         // When the table holds stops, half of the sets aim at a stop already held.
         if (shadow_held > 0 && $urandom_range(0, 1) == 1)
            c.ramp = {1'b0, shadow_stops[$urandom_range(0, shadow_held - 1)].ramp};
      end else if (r < 63) begin
         c.cmd = CMD_REMOVE;
      end else if (r < 85) begin
         c.cmd = CMD_READ;
      end else if (r < 93) begin
         c.cmd = CMD_FILTER;
      end else if (r < 94) begin
         c.cmd = CMD_CLEAR;
      end else if (r < 97) begin
         c.cmd = CMD_SPARE_A;
      end else begin
         c.cmd = CMD_SPARE_B;
      end
      return c;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows
   // the acceptance.
   task automatic send_stop_cmd(stop_cmd_type c);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.cmd        <= c.cmd;
      req_ch.ramp_in    <= c.ramp;
      req_ch.mid_in     <= c.mid;
      req_ch.opacity_in <= c.opacity;
      req_ch.shade_in   <= c.shade;
      req_ch.color_id   <= c.color;
      req_ch.name_id    <= c.name;
      req_ch.index_in   <= c.idx;
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(apply_stop_cmd(c));
      cmd_tally[c.cmd]++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_empty_table();
      send_stop_cmd(stop_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_FILTER, 0, 0, 0, 0, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_SPARE_A, 100, 200, 300, 400, 16'hffff, 16'hffff, 255));
      send_stop_cmd(stop_cmd(CMD_SPARE_B, -1, -1, -1, -1, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_add_clamp_and_order();
      send_stop_cmd(stop_cmd(CMD_ADD, -65536, 65535, -1, 32768, 0, 16'hffff, 0));
      send_stop_cmd(stop_cmd(CMD_ADD, 32769, -65536, 32768, 65535, 16'hffff, 0, 0));
      send_stop_cmd(stop_cmd(CMD_ADD, 0, 16384, 32767, 1, 16'h5a5a, 16'ha5a5, 0));
      send_stop_cmd(stop_cmd(CMD_ADD, 65535, 0, 0, 0, 16'h1234, 16'h4321, 0));
      send_stop_cmd(stop_cmd(CMD_ADD, 12345, 32767, 1, -32768, 16'h00ff, 16'hff00, 0));
      send_stop_cmd(stop_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 1));
      send_stop_cmd(stop_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 4));
   endtask

   task automatic test_set_and_filter();
      // Matches a held stop at one, so it is moved rather than duplicated.
      send_stop_cmd(stop_cmd(CMD_SET, 32768, 100, 200, 300, 16'hbeef, 16'hcafe, 0));
      // Above one before clamping, so nothing matches and it is added.
      send_stop_cmd(stop_cmd(CMD_SET, 40000, 1, 2, 3, 16'h0001, 16'h0002, 0));
      send_stop_cmd(stop_cmd(CMD_SET, -5, 7, 8, 9, 16'h0003, 16'h0004, 0));
      send_stop_cmd(stop_cmd(CMD_FILTER, 0, 0, 0, 0, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0));
      send_stop_cmd(stop_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 255));
   endtask

   task automatic test_full_table();
      stop_cmd_type c;
      while (shadow_held < MAX_STOPS) begin
         c = random_stop_cmd();
         c.cmd = CMD_ADD;
         send_stop_cmd(c);
      end
      send_stop_cmd(stop_cmd(CMD_ADD, 1000, 1, 1, 1, 16'h0bad, 16'h0bad, 0));
      send_stop_cmd(stop_cmd(CMD_SET, -1, 1, 1, 1, 16'h0bad, 16'h0bad, 0));
      send_stop_cmd(stop_cmd(CMD_SET, {1'b0, shadow_stops[5].ramp}, 9, 9, 9, 16'h600d,
                             16'h600d, 0));
      send_stop_cmd(stop_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, MAX_STOPS - 1));
      send_stop_cmd(stop_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, MAX_STOPS));
      send_stop_cmd(stop_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_mix(int items);
      int i;
      for (i = 0; i < items; i++) begin
         idle_on = ((i / 100) % 3) != 2;
         if (i % 250 == 249) wait_for_drain();
         send_stop_cmd(random_stop_cmd());
      end
   endtask

   // Response side: a random stall before each item, none in the quiet stretches.
   initial begin : rsp_ready_driver
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      stop_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            $display("%0t ns: response item with nothing outstanding, status %0h", $time,
                     rsp_ch.status);
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_ch.status));
            check_field("stop_count", 16'(want.count), 16'(rsp_ch.stop_count));
            check_field("slot_index", 16'(want.slot), 16'(rsp_ch.slot_index));
            check_field("ramp_out", want.stop.ramp, rsp_ch.ramp_out);
            check_field("mid_out", want.stop.mid, rsp_ch.mid_out);
            check_field("opacity_out", want.stop.opacity, rsp_ch.opacity_out);
            check_field("shade_out", want.stop.shade, rsp_ch.shade_out);
            check_field("color_out", want.stop.color, rsp_ch.color_out);
            check_field("name_out", want.stop.name, rsp_ch.name_out);
            checked_count++;
            if (want.status == ST_FULL) full_count++;
            if (want.status == ST_BAD_INDEX) bad_index_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.", cycle_count,
                  pending_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      idle_on           = 1'b1;
      shadow_held       = 0;
      foreach (cmd_tally[i]) cmd_tally[i] = 0;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_ADD;
      req_ch.ramp_in    = '0;
      req_ch.mid_in     = '0;
      req_ch.opacity_in = '0;
      req_ch.shade_in   = '0;
      req_ch.color_id   = '0;
      req_ch.name_id    = '0;
      req_ch.index_in   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_add_clamp_and_order();
      test_set_and_filter();
      wait_for_drain();
      test_full_table();
      test_random_mix(1000);

      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Checked %0d responses: %0d add, %0d set, %0d remove, %0d read, %0d filter,",
               checked_count, cmd_tally[CMD_ADD], cmd_tally[CMD_SET], cmd_tally[CMD_REMOVE],
               cmd_tally[CMD_READ], cmd_tally[CMD_FILTER]);
      $display("%0d clear, %0d unused; %0d table-full and %0d bad-index responses seen.",
               cmd_tally[CMD_CLEAR], cmd_tally[CMD_SPARE_A] + cmd_tally[CMD_SPARE_B],
               full_count, bad_index_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/scst_pkg.sv
sv/scst_if.sv
sv/scst_datapath.sv
sv/scst_controller.sv
sv/sorted_color_stop_table.sv
verif/sorted_color_stop_table_tb.sv
